/* rtl/core/pal_pkg.sv */
package pal_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);

    // Fixed field widths of the request and result channels.
    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_DELETE     = 3'd5,
        REQ_DUMP       = 3'd6,
        REQ_UNUSED     = 3'd7
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // One write and one read request towards the list memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

/* rtl/core/pal_ram.sv */
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data is registered and held until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/positional_array_list_core.sv */
// Chan  Ports                                                   Dir  Moves
// s_    s_valid s_ready s_req_type s_position s_value           in   one request per transfer
// m_    m_valid m_ready m_status m_count m_element m_last       out  one result per transfer
//
// One request is handled at a time. Pop back, rejected requests, push back, and push front
// on an empty list need no shift. Insert and push front move each element from the index up
// one place, delete and pop front each element above it down one place (no shift when the
// last element goes), by the one-element-per-cycle shift through the single read and write
// port of the list memory. A dump reads out and sends the elements one at a time.
// Reset clears the count and the control state only; the memory needs no clearing pass.
// A result waiting on m_ready holds back the next result, not the acceptance of a request.
module positional_array_list_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pal_pkg::REQ_W-1:0]    s_req_type,
    input  logic [pal_pkg::POS_W-1:0]    s_position,
    input  logic signed [pal_pkg::DATA_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pal_pkg::STAT_W-1:0]   m_status,
    output logic [pal_pkg::CNT_W-1:0]    m_count,
    output logic signed [pal_pkg::DATA_W-1:0] m_element,
    output logic                         m_last
);

    import pal_pkg::*;

    // The sequencer: IDLE takes a request, the shift states move one element per cycle
    // (a read issued in one cycle is written back one place further in the next), and
    // RESP waits for the output register to be free.
    typedef enum logic [2:0] {
        IDLE,
        INS_SHIFT,
        INS_PUT,
        DEL_SHIFT,
        DEL_DRAIN,
        DUMP_RD,
        DUMP_OUT,
        RESP
    } state_t;

    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic [ADDR_W-1:0] ptr_reg,    ptr_next;
    logic              wpend_reg,  wpend_next;
    logic [ADDR_W-1:0] waddr_reg,  waddr_next;
    logic [DATA_W-1:0] value_reg,  value_next;
    status_t           status_reg, status_next;

    logic              m_valid_reg,   m_valid_next;
    status_t           m_status_reg,  m_status_next;
    logic [CNT_W-1:0]  m_count_reg,   m_count_next;
    logic [DATA_W-1:0] m_element_reg, m_element_next;
    logic              m_last_reg,    m_last_next;

    mem_req_t          mreq;
    logic [DATA_W-1:0] rd_data;

    logic              accept;
    logic              out_free;
    logic              full;
    logic              empty;
    logic              pos_bad;
    logic [ADDR_W-1:0] pos_idx;
    logic [ADDR_W-1:0] last_idx;
    req_t              req;

    assign req      = req_t'(s_req_type);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pos_bad  = (s_position == '0) || (s_position > cnt_reg);
    assign pos_idx  = ADDR_W'(s_position - POS_W'(1));
    assign last_idx = ADDR_W'(cnt_reg - CNT_W'(1));

    assign s_ready = (state_reg == IDLE);

    // Memory port: a pending shift write has priority; the new value goes in once the
    // shift has drained.
    always_comb begin
        mreq         = '0;
        mreq.rd_addr = ptr_reg;
        if (wpend_reg) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = waddr_reg;
            mreq.wr_data = rd_data;
        end else if (state_reg == INS_PUT) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = idx_reg;
            mreq.wr_data = value_reg;
        end
        if (state_reg == INS_SHIFT || state_reg == DEL_SHIFT || state_reg == DUMP_RD) begin
            mreq.rd_en = 1'b1;
        end
    end

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mreq.wr_en),
        .wr_addr (mreq.wr_addr),
        .wr_data (mreq.wr_data),
        .rd_en   (mreq.rd_en),
        .rd_addr (mreq.rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        wpend_next     = 1'b0;
        waddr_next     = waddr_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_count_next   = m_count_reg;
        m_element_next = m_element_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    value_next  = s_value;
                    status_next = ST_OK;
                    state_next  = RESP;
                    priority case (req)
                        REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else if (req == REQ_INSERT && pos_bad) begin
                                status_next = ST_BADPOS;
                            end else begin
                                if (req == REQ_PUSH_BACK) begin
                                    idx_next = ADDR_W'(cnt_reg);
                                end else if (req == REQ_PUSH_FRONT) begin
                                    idx_next = '0;
                                end else begin
                                    idx_next = pos_idx;
                                end
                                // Appending needs no shift.
                                if (req == REQ_PUSH_BACK || empty) begin
                                    state_next = INS_PUT;
                                end else begin
                                    ptr_next   = last_idx;
                                    state_next = INS_SHIFT;
                                end
                            end
                        end
                        REQ_POP_BACK: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        REQ_POP_FRONT, REQ_DELETE: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else if (req == REQ_DELETE && pos_bad) begin
                                status_next = ST_BADPOS;
                            end else begin
                                idx_next = (req == REQ_DELETE) ? pos_idx : '0;
                                // Removing the last element needs no shift.
                                if ((req == REQ_DELETE ? pos_idx : ADDR_W'(0)) == last_idx)
                                begin
                                    cnt_next = cnt_reg - CNT_W'(1);
                                end else begin
                                    ptr_next   = (req == REQ_DELETE ? pos_idx : ADDR_W'(0))
                                                 + ADDR_W'(1);
                                    state_next = DEL_SHIFT;
                                end
                            end
                        end
                        REQ_DUMP: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ptr_next   = '0;
                                state_next = DUMP_RD;
                            end
                        end
                        default: begin
                            status_next = ST_BADPOS;
                        end
                    endcase
                end
            end
            INS_SHIFT: begin
                // Element read now lands one place higher in the next cycle.
                wpend_next = 1'b1;
                waddr_next = ptr_reg + ADDR_W'(1);
                if (ptr_reg == idx_reg) begin
                    state_next = INS_PUT;
                end else begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            INS_PUT: begin
                if (!wpend_reg) begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = RESP;
                end
            end
            DEL_SHIFT: begin
                wpend_next = 1'b1;
                waddr_next = ptr_reg - ADDR_W'(1);
                if (ptr_reg == last_idx) begin
                    state_next = DEL_DRAIN;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            DEL_DRAIN: begin
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = RESP;
            end
            DUMP_RD: begin
                state_next = DUMP_OUT;
            end
            DUMP_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = ST_OK;
                    m_count_next   = cnt_reg;
                    m_element_next = rd_data;
                    m_last_next    = (ptr_reg == last_idx);
                    if (ptr_reg == last_idx) begin
                        state_next = IDLE;
                    end else begin
                        ptr_next   = ptr_reg + ADDR_W'(1);
                        state_next = DUMP_RD;
                    end
                end
            end
            RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_count_next   = cnt_reg;
                    m_element_next = '0;
                    m_last_next    = 1'b1;
                    state_next     = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            wpend_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wpend_reg   <= wpend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        waddr_reg     <= waddr_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        m_status_reg  <= m_status_next;
        m_count_reg   <= m_count_next;
        m_element_reg <= m_element_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_count   = m_count_reg;
    assign m_element = m_element_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTHESIS
    // The count never exceeds the capacity.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

    // All shift writes have drained before a new request can be taken.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == IDLE |-> !mreq.wr_en)
        else $error("memory write while idle");

    // The count moves by at most one per cycle.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cnt_reg == $past(cnt_reg))
                        || (cnt_reg == $past(cnt_reg) + CNT_W'(1))
                        || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("element count jumped");

    // A rejected request gives a single result with no element.
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_last_reg && m_element_reg == '0)
        else $error("malformed error result");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
    import pal_pkg::*;

    // A run ends as a failure when this many cycles pass without any transfer on
    // either channel. The slowest legal stretch is an insert at the front of a list
    // one short of full with both sides stalling.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the final result, so that any stray result still shows.
    localparam int SETTLE_CYCLES  = 150;
    // Only this many failures are described. Any after that are only counted.
    localparam int REPORT_CAP     = 10;

    // Keeps a copy of the list, works out the results that each accepted request
    // should give, and checks the results that come back in order.
    class list_scoreboard;
        typedef struct {
            status_t                  status;
            logic [CNT_W-1:0]         count;
            logic signed [DATA_W-1:0] element;
            logic                     last;
        } list_result_t;

        logic signed [DATA_W-1:0] held_values[$];
        list_result_t             awaited[$];
        int unsigned              failures = 0;

        function void complain(string msg);
            if (failures < REPORT_CAP) begin
                $display("check: %s", msg);
            end
            failures++;
        endfunction

        function int unsigned held();
            return held_values.size();
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_request(req_t req, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            status_t     st;
            int unsigned n;
            int unsigned i;
            bit          full;
            bit          empty;
            bit          bad_pos;
            st      = ST_OK;
            n       = held_values.size();
            full    = (n >= DEPTH);
            empty   = (n == 0);
            bad_pos = (pos == 0) || (pos > n);
            case (req)
                REQ_PUSH_BACK: begin
                    if (full) st = ST_FULL;
                    else held_values.push_back(val);
                end
                REQ_POP_BACK: begin
                    if (empty) st = ST_EMPTY;
                    else void'(held_values.pop_back());
                end
                REQ_PUSH_FRONT: begin
                    if (full) st = ST_FULL;
                    else held_values.push_front(val);
                end
                REQ_POP_FRONT: begin
                    if (empty) st = ST_EMPTY;
                    else void'(held_values.pop_front());
                end
                REQ_INSERT: begin
                    // A full list is reported ahead of a bad position.
                    if (full) st = ST_FULL;
                    else if (bad_pos) st = ST_BADPOS;
                    else held_values.insert(int'(pos) - 1, val);
                end
                REQ_DELETE: begin
                    if (empty) st = ST_EMPTY;
                    else if (bad_pos) st = ST_BADPOS;
                    else held_values.delete(int'(pos) - 1);
                end
                REQ_DUMP: begin
                    if (empty) begin
                        awaited.push_back('{status: ST_EMPTY, count: '0, element: 0,
                                            last: 1'b1});
                    end else begin
                        for (i = 0; i < n; i++) begin
                            awaited.push_back('{status: ST_OK, count: CNT_W'(n),
                                                element: held_values[i],
                                                last: (i + 1 == n)});
                        end
                    end
                    return;
                end
                default: st = ST_BADPOS;
            endcase
            awaited.push_back('{status: st, count: CNT_W'(held_values.size()),
                                element: 0, last: 1'b1});
        endfunction

        function void check_result(status_t st, logic [CNT_W-1:0] cnt,
                                   logic signed [DATA_W-1:0] el, logic lst);
            list_result_t want;
            if (awaited.size() == 0) begin
                complain($sformatf("unexpected result status=%0d count=%0d element=%0d last=%0d",
                                   st, cnt, el, lst));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status || cnt !== want.count || el !== want.element
                    || lst !== want.last) begin
                complain($sformatf({"result differs: expected status=%0d count=%0d ",
                                    "element=%0d last=%0d, got status=%0d count=%0d ",
                                    "element=%0d last=%0d"},
                                   want.status, want.count, want.element, want.last,
                                   st, cnt, el, lst));
            end
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic                     aclk       = 1'b0;
    logic                     aresetn    = 1'b0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type = '0;
    logic [POS_W-1:0]         s_position = '0;
    logic signed [DATA_W-1:0] s_value    = '0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic [CNT_W-1:0]         m_count;
    logic signed [DATA_W-1:0] m_element;
    logic                     m_last;

    // Percentages of cycles in which the sender and the receiver hold back.
    int send_idle = 36;
    int recv_idle = 61;

    int idle_cycles = 0;
    bit timed_out   = 1'b0;
    // The random traffic swings between building the list up and wearing it down,
    // so that both the full and the empty list are reached with real content.
    bit growing     = 1'b1;

    list_scoreboard sb = new;

    positional_array_list_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_position (s_position),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_element  (m_element),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls at random, one decision per cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Each result transfer is checked against the oldest outstanding expectation.
    // Values are read at the edge itself, so they are the ones the block presented.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(status_t'(m_status), m_count, m_element, m_last);
        end
    end

    // Counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and holds it until the transfer completes. Valid is left
    // high afterwards, so back-to-back requests need only one assignment per edge;
    // it is lowered only when the sender idles or pauses.
    task automatic send_request(req_t req, int pos, logic signed [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_position <= POS_W'(pos);
        s_value    <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(req, POS_W'(pos), val);
    endtask

    // Stops sending until every expected result has been transferred. At least one
    // edge always passes, so valid is never lowered and raised in the same step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Directed opening: every request but push front on an empty list, the extremes of the value
    // field, positions at both ends and just outside the list, and the unused code.
    task automatic run_directed();
        send_request(REQ_DUMP, 0, 0);                    // dump of an empty list
        send_request(REQ_POP_BACK, 0, 0);
        send_request(REQ_POP_FRONT, 0, 0);
        send_request(REQ_DELETE, 1, 0);
        send_request(REQ_INSERT, 1, 32'sh1111_1111);     // nothing to insert before
        send_request(REQ_UNUSED, 127, 32'shFFFF_FFFF);
        send_request(REQ_PUSH_BACK, 0, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 0, 32'sh8000_0000);
        send_request(REQ_PUSH_BACK, 0, 0);
        send_request(REQ_PUSH_BACK, 0, -1);
        send_request(REQ_INSERT, 1, 12345);              // new head
        send_request(REQ_INSERT, 5, 32'shA5A5_A5A5);     // before the tail
        send_request(REQ_INSERT, 0, 7);
        send_request(REQ_INSERT, 7, 8);                  // one past the end
        send_request(REQ_INSERT, 127, 32'sh5A5A_5A5A);
        send_request(REQ_DUMP, 0, 0);
        send_request(REQ_DELETE, 0, 0);
        send_request(REQ_DELETE, 127, 0);
        send_request(REQ_DELETE, 6, 0);                  // the tail
        send_request(REQ_DELETE, 1, 0);                  // the head
        send_request(REQ_DELETE, 2, 0);                  // the middle
        send_request(REQ_POP_BACK, 0, 0);
        send_request(REQ_POP_FRONT, 0, 0);
        send_request(REQ_DUMP, 0, 0);
    endtask

    // Random traffic with random values. Positions are mostly inside the list, with
    // a share of zero, one past the end, and anything the field can hold.
    task automatic random_requests(int n);
        int          roll;
        int          pick;
        int unsigned cnt;
        int          pos;
        req_t        req;
        repeat (n) begin
            cnt = sb.held();
            // Linger a few requests at each extreme before turning round.
            if (growing && cnt == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
            else if (!growing && cnt == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 2);
            if (roll < 6) begin
                req = REQ_DUMP;
            end else if (roll < 8) begin
                req = REQ_UNUSED;
            end else if (roll < (growing ? 86 : 22)) begin
                req = (pick == 0) ? REQ_PUSH_BACK : (pick == 1) ? REQ_PUSH_FRONT : REQ_INSERT;
            end else begin
                req = (pick == 0) ? REQ_POP_BACK : (pick == 1) ? REQ_POP_FRONT : REQ_DELETE;
            end
            roll = $urandom_range(0, 9);
            if ((req == REQ_INSERT || req == REQ_DELETE) && roll < 8 && cnt > 0) begin
                pos = $urandom_range(1, cnt);
            end else if (roll == 8) begin
                pos = $urandom_range(0, 1) ? int'(cnt) + 1 : 0;
            end else begin
                pos = $urandom_range(0, 127);
            end
            send_request(req, pos, $urandom);
        end
    endtask

    initial begin
        fork
            begin
                repeat (10) @(posedge aclk);
                aresetn <= 1'b1;
                @(posedge aclk);
                // The first phase stalls the receiver more than the sender, the
                // second the reverse, and the third runs both flat out. Between
                // phases the sender waits for every outstanding result.
                run_directed();
                wait_for_results();
                random_requests(69);
                wait_for_results();
                send_idle = 61;
                recv_idle = 36;
                random_requests(69);
                wait_for_results();
                send_idle = 0;
                recv_idle = 0;
                random_requests(68);
                wait_for_results();
                repeat (SETTLE_CYCLES) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out) begin
            $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
        end else if (sb.pending() != 0) begin
            sb.complain($sformatf("%0d results never arrived", sb.pending()));
        end
        if (timed_out || sb.failures != 0) begin
            $display("testbench: done, errors");
        end else begin
            $display("testbench: done, clean");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pal_pkg.sv
rtl/core/pal_ram.sv
rtl/core/positional_array_list_core.sv
tb/testbench.sv
